### design/ogbu_pkg.sv
// shared constants, types and helpers of the occupancy grid blend update core
`default_nettype none

package ogbu_pkg;

	// grid store geometry, cell (x,y) lives at y*MaxWidth + x
	localparam int MaxWidth  = 256;
	localparam int MaxLength = 256;
	localparam int XW        = $clog2(MaxWidth);
	localparam int YW        = $clog2(MaxLength);
	localparam int AddrW     = XW + YW;
	localparam int Depth     = MaxWidth * MaxLength;

	// field and register widths
	localparam int QW      = 16;
	localparam int GridW   = 9;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;
	localparam int ProbW   = 17;
	localparam int ProdW   = 2 * QW;

	// q1.15 constants
	localparam logic [QW-1:0] QOne  = 16'd32768;
	localparam logic [QW-1:0] QHalf = 16'd16384;

	localparam logic signed [ProbW-1:0] ProbOutside = -17'sd32768;

	// item kinds, the unused code behaves as a query
	typedef enum logic [1:0] {
		KIND_OBSERVE = 2'd0,
		KIND_QUERY   = 2'd1,
		KIND_CLEAR   = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_GRID_WIDTH    = 3'd0,
		CFG_GRID_LENGTH   = 3'd1,
		CFG_OCC_TARGET    = 3'd2,
		CFG_FREE_TARGET   = 3'd3,
		CFG_UPDATE_GAIN   = 3'd4,
		CFG_OCC_THRESHOLD = 3'd5
	} cfg_idx_t;

	// register reset values
	localparam logic [GridW-1:0] RstGridWidth    = 9'd256;
	localparam logic [GridW-1:0] RstGridLength   = 9'd256;
	localparam logic [QW-1:0]    RstOccTarget    = 16'd29491;
	localparam logic [QW-1:0]    RstFreeTarget   = 16'd3277;
	localparam logic [QW-1:0]    RstUpdateGain   = 16'd9830;
	localparam logic [QW-1:0]    RstOccThreshold = 16'd22938;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // latch the accepted item
		logic sweep;  // write one half to the sweep address and step it
		logic rd;     // read the addressed cell, form target*gain
		logic mul;    // form p*(1-gain)
		logic fin;    // finish the blend, write back, load the result register
	} ogbu_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_clear;    // latched item is a clear
		logic sweep_last;  // sweep address at the last cell
		logic out_free;    // result register can take a new result
	} ogbu_sts_t;

	// saturate a q1.15 register value to 1.0
	function automatic logic [QW-1:0] sat_q(input logic [QW-1:0] v);
		sat_q = (v > QOne) ? QOne : v;
	endfunction

endpackage

`default_nettype wire

### design/occupancy_grid_blend_update_core.sv
// top level of the occupancy grid blend update core
`default_nettype none

// channel   dir  transaction contents
// s_axis    in   tuser: kind[1:0]; tdata: cell_x[15:0], cell_y[31:16], obstacle_seen[32]
// m_axis    out  tdata: probability[16:0], occupied[17], in_range[18]
// cfg       in   cfg_we, cfg_index (register number), cfg_data (value, low bits used)
//
// observe or query: after acceptance the item passes the sweep check, the store read, the multiply
// and the finish; the next item is taken only after the finish, so one item is in flight at a time
// a clear item holds the sweep check while it sets every cell to one half, one store write a cycle, then goes on
// after reset a pass sets every cell to one half with s_axis_tready low;
// configuration writes are taken meanwhile
// a stalled m_axis holds the finish stage until the result register frees, s_axis waits

module occupancy_grid_blend_update_core
	import ogbu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input items
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [39:0]          s_axis_tdata,  // cell_x, cell_y, obstacle_seen, zero pad
	input  wire logic [1:0]           s_axis_tuser,  // kind
	// results
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // probability, occupied, in_range, zero pad
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [CfgW-1:0]      cfg_data
);

	ogbu_cmd_t cmd;
	ogbu_sts_t sts;

	logic signed [ProbW-1:0] probability;
	logic                    occupied;
	logic                    in_range;

	// sequencing of sweeps, reads, multiply and finish
	ogbu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// registers, cell store and blend arithmetic
	ogbu_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (s_axis_tuser),
		.cell_x        (s_axis_tdata[15:0]),
		.cell_y        (s_axis_tdata[31:16]),
		.obstacle_seen (s_axis_tdata[32]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.probability   (probability),
		.occupied      (occupied),
		.in_range      (in_range)
	);

	// pack the result fields, lowest field first
	assign m_axis_tdata = {5'b0, in_range, occupied, probability};

endmodule

`default_nettype wire

### design/ogbu_ctrl.sv
// controller state machine of the occupancy grid blend update core
`default_nettype none

module ogbu_ctrl
	import ogbu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  ogbu_sts_t      sts,
	output ogbu_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_INIT:  cmd.sweep = 1'b1;
			ST_IDLE:  cmd.load  = in_valid;
			// only a clear item writes the store here
			ST_CLEAR: cmd.sweep = sts.is_clear;
			ST_READ:  cmd.rd    = 1'b1;
			ST_MUL:   cmd.mul   = 1'b1;
			ST_FIN:   cmd.fin   = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					// a non-clear item skips the sweep at once
					if (!sts.is_clear || sts.sweep_last) state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/ogbu_dpath.sv
// datapath of the occupancy grid blend update core: registers, cell store, blend arithmetic
`default_nettype none

module ogbu_dpath
	import ogbu_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  ogbu_cmd_t                    cmd,
	output ogbu_sts_t                    sts,
	input  wire logic [1:0]              kind,
	input  wire logic signed [QW-1:0]    cell_x,
	input  wire logic signed [QW-1:0]    cell_y,
	input  wire logic                    obstacle_seen,
	input  wire logic                    cfg_we,
	input  wire logic [CfgIdxW-1:0]      cfg_index,
	input  wire logic [CfgW-1:0]         cfg_data,
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output logic signed [ProbW-1:0]      probability,
	output logic                         occupied,
	output logic                         in_range
);

	// configuration registers
	logic [GridW-1:0] grid_width_q;
	logic [GridW-1:0] grid_length_q;
	logic [QW-1:0]    occ_target_q;
	logic [QW-1:0]    free_target_q;
	logic [QW-1:0]    update_gain_q;
	logic [QW-1:0]    occ_threshold_q;

	// latched item
	logic [1:0]       kind_q;
	logic             obstacle_q;
	logic             in_grid_q;
	logic [AddrW-1:0] addr_q;

	// sweep and arithmetic
	logic [AddrW-1:0] sweep_cnt_q;
	logic [QW-1:0]    rd_q;
	logic [ProdW-1:0] tg_q;
	logic [ProdW-1:0] prod_q;

	// result register
	logic                    out_valid_q;
	logic signed [ProbW-1:0] prob_q;
	logic                    occ_q;
	logic                    inr_q;

	logic [QW-1:0] mem [Depth];

	logic [GridW-1:0]  w_eff;
	logic [GridW-1:0]  l_eff;
	logic              in_grid;
	logic [QW-1:0]     gain_sat;
	logic [QW-1:0]     target_sat;
	logic [ProdW:0]    acc;
	logic [ProdW-QW:0] blend;
	logic [QW-1:0]     new_p;
	logic [QW-1:0]     res_p;
	logic              upd;
	logic              mem_we;
	logic [AddrW-1:0]  mem_wa;
	logic [QW-1:0]     mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= RstGridWidth;
			grid_length_q   <= RstGridLength;
			occ_target_q    <= RstOccTarget;
			free_target_q   <= RstFreeTarget;
			update_gain_q   <= RstUpdateGain;
			occ_threshold_q <= RstOccThreshold;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:    grid_width_q    <= cfg_data[GridW-1:0];
				CFG_GRID_LENGTH:   grid_length_q   <= cfg_data[GridW-1:0];
				CFG_OCC_TARGET:    occ_target_q    <= cfg_data;
				CFG_FREE_TARGET:   free_target_q   <= cfg_data;
				CFG_UPDATE_GAIN:   update_gain_q   <= cfg_data;
				CFG_OCC_THRESHOLD: occ_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// range check, negative coordinates fail on the sign bit
	assign w_eff = (grid_width_q > GridW'(MaxWidth)) ? GridW'(MaxWidth) : grid_width_q;
	assign l_eff = (grid_length_q > GridW'(MaxLength)) ? GridW'(MaxLength) : grid_length_q;
	assign in_grid = !cell_x[QW-1] && !cell_y[QW-1]
		&& (unsigned'(cell_x) < QW'(w_eff)) && (unsigned'(cell_y) < QW'(l_eff));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= kind;
			obstacle_q <= obstacle_seen;
			in_grid_q  <= in_grid;
			addr_q     <= AddrW'(AddrW'(cell_y[YW-1:0]) * AddrW'(MaxWidth))
				+ AddrW'(cell_x[XW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep) begin
			sweep_cnt_q <= sweep_cnt_q + AddrW'(1);
		end
	end

	assign gain_sat   = sat_q(update_gain_q);
	assign target_sat = sat_q(obstacle_q ? occ_target_q : free_target_q);

	always_ff @(posedge clk) begin
		if (cmd.rd) tg_q <= target_sat * gain_sat;
		if (cmd.mul) prod_q <= rd_q * (QOne - gain_sat);
	end

	// round half up, drop 15 fraction bits, clamp at one
	assign acc   = {1'b0, prod_q} + {1'b0, tg_q} + (ProdW+1)'(QHalf);
	assign blend = acc[ProdW-1:QW-1];
	assign new_p = (blend > (ProdW-QW+1)'(QOne)) ? QOne : blend[QW-1:0];

	assign upd   = in_grid_q && (kind_q == KIND_OBSERVE);
	assign res_p = upd ? new_p : rd_q;

	assign mem_we = cmd.sweep || (cmd.fin && upd);
	assign mem_wa = cmd.sweep ? sweep_cnt_q : addr_q;
	assign mem_wd = cmd.sweep ? QHalf : new_p;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.rd) rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			prob_q <= in_grid_q ? signed'({1'b0, res_p}) : ProbOutside;
			occ_q  <= in_grid_q && (res_p > sat_q(occ_threshold_q));
			inr_q  <= in_grid_q;
		end
	end

	assign sts.is_clear   = (kind_q == KIND_CLEAR);
	assign sts.sweep_last = (sweep_cnt_q == AddrW'(Depth - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign probability = prob_q;
	assign occupied    = occ_q;
	assign in_range    = inr_q;

endmodule

`default_nettype wire

### bench/occupancy_grid_blend_update_core_tb.sv
// self-checking testbench for the occupancy grid blend update core
module occupancy_grid_blend_update_core_tb
	import ogbu_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// the spare kind code has no package name, the core treats it as a query
	localparam logic [1:0] KIND_SPARE = 2'd3;
	// longest run of cycles with no transaction on either side before giving up
	localparam int unsigned StallLimit = 300000;
	localparam int unsigned HoldCycles = 400;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] x;
		logic [15:0] y;
		logic        obstacle;
	} grid_obs_t;

	typedef struct packed {
		logic signed [ProbW-1:0] prob;
		logic                    occupied;
		logic                    in_range;
	} cell_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [23:0]  m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;

	occupancy_grid_blend_update_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // cell_x, cell_y, obstacle_seen, zero pad
		.s_axis_tuser  (s_axis_tuser),  // kind
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // probability, occupied, in_range, zero pad
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// shadow of the grid and of the registers
	// ---------------------------------------------------------------
	logic [QW-1:0]    cell_shadow [Depth];
	logic [GridW-1:0] cols_reg   = RstGridWidth;
	logic [GridW-1:0] rows_reg   = RstGridLength;
	logic [QW-1:0]    occ_tgt_reg = RstOccTarget;
	logic [QW-1:0]    free_tgt_reg = RstFreeTarget;
	logic [QW-1:0]    gain_reg   = RstUpdateGain;
	logic [QW-1:0]    thresh_reg = RstOccThreshold;

	grid_obs_t    sensor_items [$];      // waiting to be offered
	cell_report_t expected_reports [$];  // predicted, not yet seen

	int unsigned n_observe, n_query, n_clear, n_outside, n_checked, n_errors;
	int unsigned clears_budget;
	bit          sender_idle_on = 1'b1;
	bit          receiver_idle_on = 1'b1;
	bit          hold_req = 1'b0;

	function automatic void fill_cells_half();
		for (int i = 0; i < Depth; i++)
			cell_shadow[i] = QHalf;
	endfunction

	initial fill_cells_half();

	// registers above 1.0 act as 1.0
	function automatic int unsigned q_limit(logic [QW-1:0] v);
		return (v > QOne) ? int'(QOne) : int'(v);
	endfunction

	function automatic int unsigned eff_cols();
		return (cols_reg > MaxWidth) ? MaxWidth : cols_reg;
	endfunction

	function automatic int unsigned eff_rows();
		return (rows_reg > MaxLength) ? MaxLength : rows_reg;
	endfunction

	// blend or read the addressed cell and queue the report the core must give
	function automatic void predict_cell_report(grid_obs_t it);
		int unsigned  ux, uy, idx, g, t;
		longint unsigned acc;
		logic         in_grid;
		cell_report_t rep;
		ux = {16'd0, it.x};
		uy = {16'd0, it.y};
		// negative coordinates carry bit 15 and fall outside any width
		in_grid = !it.x[15] && !it.y[15] && ux < eff_cols() && uy < eff_rows();
		if (it.kind == KIND_CLEAR) begin
			fill_cells_half();
			n_clear++;
		end else if (it.kind == KIND_OBSERVE)
			n_observe++;
		else
			n_query++;
		if (in_grid) begin
			idx = uy * MaxWidth + ux;
			if (it.kind == KIND_OBSERVE) begin
				g = q_limit(gain_reg);
				t = q_limit(it.obstacle ? occ_tgt_reg : free_tgt_reg);
				acc = longint'(cell_shadow[idx]) * (QOne - g) + longint'(t) * g + QHalf;
				acc = acc >> 15;
				if (acc > QOne)
					acc = QOne;
				cell_shadow[idx] = QW'(acc);
			end
			rep.prob     = ProbW'(cell_shadow[idx]);
			rep.occupied = cell_shadow[idx] > q_limit(thresh_reg);
			rep.in_range = 1'b1;
		end else begin
			n_outside++;
			rep.prob     = ProbOutside;
			rep.occupied = 1'b0;
			rep.in_range = 1'b0;
		end
		expected_reports.push_back(rep);
	endfunction

	// ---------------------------------------------------------------
	// random helpers
	// ---------------------------------------------------------------
	// mostly back to back, often short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// coordinate near the used part of the grid, with edge and wild values
	function automatic logic [15:0] random_coord(int unsigned span);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return 16'($urandom_range(0, (span < 8) ? span + 1 : 7));
		else if (r < 15)
			return 16'($urandom_range(0, span + 1));
		else if (r < 17)
			return 16'hFFFF - 16'($urandom_range(0, 2));
		else if (r < 19)
			return 16'($urandom());
		return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
	endfunction

	function automatic grid_obs_t random_obs();
		grid_obs_t   it;
		int unsigned r;
		r = $urandom_range(0, 199);
		if (r == 0 && clears_budget > 0) begin
			it.kind = KIND_CLEAR;
			clears_budget--;
		end else if (r < 110)
			it.kind = KIND_OBSERVE;
		else if (r < 190)
			it.kind = KIND_QUERY;
		else
			it.kind = KIND_SPARE;
		it.x        = random_coord(eff_cols());
		it.y        = random_coord(eff_rows());
		it.obstacle = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void queue_obs(logic [1:0] kind, logic [15:0] x, logic [15:0] y,
			logic obstacle);
		grid_obs_t it;
		it.kind     = kind;
		it.x        = x;
		it.y        = y;
		it.obstacle = obstacle;
		sensor_items.push_back(it);
	endfunction

	// ---------------------------------------------------------------
	// input driver: offers queued items, predicts on each accepted transaction
	// ---------------------------------------------------------------
	grid_obs_t   offered_item;
	int unsigned send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_cell_report(offered_item);
			// the slot is free when nothing is offered or the offer was just taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (sensor_items.size() > 0) begin
					offered_item  <= sensor_items[0];
					s_axis_tdata  <= {7'd0, sensor_items[0].obstacle, sensor_items[0].y,
						sensor_items[0].x};
					s_axis_tuser  <= sensor_items[0].kind;
					s_axis_tvalid <= 1'b1;
					send_gap      <= sender_idle_on ? pick_gap() : 0;
					void'(sensor_items.pop_front());
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: random back pressure plus one long hold-off
	// ---------------------------------------------------------------
	int unsigned recv_gap, hold_left;
	bit          hold_done;

	function automatic void check_cell_report(logic [23:0] data);
		cell_report_t want, got;
		got = {data[16:0], data[17], data[18]};
		n_checked++;
		if (expected_reports.size() == 0) begin
			$display("%0t ns: unexpected result transaction, data %h", $time, data);
			n_errors++;
			return;
		end
		want = expected_reports.pop_front();
		if (got.prob !== want.prob) begin
			$display("%0t ns: probability mismatch, expected %0d, actual %0d",
				$time, want.prob, got.prob);
			n_errors++;
		end
		if (got.occupied !== want.occupied) begin
			$display("%0t ns: occupied mismatch, expected %0b, actual %0b",
				$time, want.occupied, got.occupied);
			n_errors++;
		end
		if (got.in_range !== want.in_range) begin
			$display("%0t ns: in_range mismatch, expected %0b, actual %0b",
				$time, want.in_range, got.in_range);
			n_errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
			hold_left     <= 0;
			hold_done     <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_cell_report(m_axis_tdata);
			if (hold_left > 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				// long stall so the core fills up and drops s_axis_tready
				hold_left     <= HoldCycles;
				hold_done     <= 1'b1;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap      <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (receiver_idle_on && $urandom_range(0, 3) == 0)
					recv_gap <= pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog on cycles without any transaction
	// ---------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= StallLimit) begin
			$display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------------------------------------------------------
	// sequencing
	// ---------------------------------------------------------------
	// registers change only while nothing is in flight
	task automatic write_grid_reg(cfg_idx_t idx, logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_GRID_WIDTH:    cols_reg     = val[GridW-1:0];
			CFG_GRID_LENGTH:   rows_reg     = val[GridW-1:0];
			CFG_OCC_TARGET:    occ_tgt_reg  = val;
			CFG_FREE_TARGET:   free_tgt_reg = val;
			CFG_UPDATE_GAIN:   gain_reg     = val;
			CFG_OCC_THRESHOLD: thresh_reg   = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows, logic [CfgW-1:0] occ,
			logic [CfgW-1:0] free, logic [CfgW-1:0] gain, logic [CfgW-1:0] thresh);
		write_grid_reg(CFG_GRID_WIDTH, cols);
		write_grid_reg(CFG_GRID_LENGTH, rows);
		write_grid_reg(CFG_OCC_TARGET, occ);
		write_grid_reg(CFG_FREE_TARGET, free);
		write_grid_reg(CFG_UPDATE_GAIN, gain);
		write_grid_reg(CFG_OCC_THRESHOLD, thresh);
	endtask

	// sampled at the falling edge so every nonblocking update has landed
	task automatic drain();
		do
			@(negedge clk);
		while (sensor_items.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
	endtask

	task automatic random_phase(int unsigned count, bit idle_on);
		@(negedge clk);
		sender_idle_on   = idle_on;
		receiver_idle_on = idle_on;
		repeat (count)
			sensor_items.push_back(random_obs());
		drain();
	endtask

	initial begin
		clears_budget = 4;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// small grid so cells get hit again and again; the core is still
		// sweeping its store, writes are taken meanwhile
		set_grid(4, 3, RstOccTarget, RstFreeTarget, RstUpdateGain, RstOccThreshold);

		// directed: repeated obstacle until the threshold is crossed
		queue_obs(KIND_OBSERVE, 0, 0, 1'b1);
		queue_obs(KIND_OBSERVE, 0, 0, 1'b1);
		queue_obs(KIND_OBSERVE, 0, 0, 1'b1);
		queue_obs(KIND_QUERY, 0, 0, 1'b0);
		// far corner and the spare kind code
		queue_obs(KIND_OBSERVE, 3, 2, 1'b0);
		queue_obs(KIND_SPARE, 3, 2, 1'b1);
		// just outside on each side, negative and extreme coordinates
		queue_obs(KIND_OBSERVE, 4, 0, 1'b1);
		queue_obs(KIND_OBSERVE, 0, 3, 1'b1);
		queue_obs(KIND_OBSERVE, 16'hFFFF, 0, 1'b0);
		queue_obs(KIND_QUERY, 0, 16'hFFFF, 1'b0);
		queue_obs(KIND_OBSERVE, 16'h8000, 16'h7FFF, 1'b1);
		queue_obs(KIND_OBSERVE, 16'h7FFF, 16'h8000, 1'b0);
		queue_obs(KIND_QUERY, 16'h7FFF, 16'h7FFF, 1'b1);
		queue_obs(KIND_OBSERVE, 1, 1, 1'b0);
		// clear reports like a query, also when aimed outside the grid
		queue_obs(KIND_CLEAR, 0, 0, 1'b0);
		queue_obs(KIND_QUERY, 3, 2, 1'b0);
		queue_obs(KIND_CLEAR, 16'hFFFB, 100, 1'b1);
		queue_obs(KIND_QUERY, 1, 1, 1'b0);
		queue_obs(KIND_OBSERVE, 2, 1, 1'b1);
		queue_obs(KIND_QUERY, 2, 1, 1'b0);
		drain();
		random_phase(160, 1'b1);

		// full grid, receiver holds off for a long stretch while the sender streams
		set_grid(256, 256, 20000, 8000, 4000, 12000);
		@(negedge clk);
		hold_req = 1'b1;
		random_phase(150, 1'b0);

		// oversized grid registers, full gain, extreme targets and threshold
		set_grid(511, 511, 32768, 0, 32768, 0);
		random_phase(120, 1'b1);

		// zero size, everything outside
		set_grid(0, 0, 1, 32767, 16384, 32767);
		random_phase(30, 1'b1);

		// single cell, no blending, threshold at one
		set_grid(1, 1, 29491, 3277, 0, 32768);
		random_phase(100, 1'b1);

		// probability registers above one saturate
		set_grid(3, 2, 16'hFFFF, 40000, 16'hFFFF, 50000);
		random_phase(120, 1'b1);

		// tiny gain
		set_grid(7, 5, 32768, 0, 1, 16384);
		random_phase(150, 1'b1);

		// random setting
		set_grid(CfgW'($urandom_range(1, 24)), CfgW'($urandom_range(1, 24)),
			CfgW'($urandom_range(16384, 32768)), CfgW'($urandom_range(0, 16384)),
			CfgW'($urandom_range(1000, 30000)), CfgW'($urandom_range(0, 32768)));
		random_phase(150, 1'b1);

		// let anything stray show up before the final check
		repeat (20) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, expected_reports.size());
			n_errors++;
		end
		$display("covered %0d observe, %0d query, %0d clear items, %0d of them outside the grid",
			n_observe, n_query, n_clear, n_outside);
		$display("checked %0d result transactions, %0d field mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
design/ogbu_pkg.sv
design/ogbu_ctrl.sv
design/ogbu_dpath.sv
design/occupancy_grid_blend_update_core.sv
bench/occupancy_grid_blend_update_core_tb.sv
